FILE: hdl/hdmp_pkg.sv
// ----------------------------------------------------------------------------
// hdmp_pkg: shared types and constants of the depth max pyramid
// Grid size, depth width, pyramid addressing and control records.
// ----------------------------------------------------------------------------
package hdmp_pkg;

    localparam int SIDE_LOG2  = 6;
    localparam int DEPTH_BITS = 24;
    localparam int COORD_W    = 6;
    localparam int SIDE       = 1 << SIDE_LOG2;
    localparam int PYR_TOTAL  = ((1 << (2 * (SIDE_LOG2 + 1))) - 1) / 3;
    localparam int ADDR_W     = $clog2(PYR_TOTAL);
    localparam int LVL_W      = $clog2(SIDE_LOG2 + 1);

    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [SIDE_LOG2-1:0]  t_xy;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [LVL_W-1:0]      t_lvl;

    localparam t_lvl  TOP_LVL  = t_lvl'(SIDE_LOG2);
    localparam t_addr CLR_LAST = t_addr'(PYR_TOTAL - 1);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_WPIX,
        S_WRD,
        S_WWB,
        S_QVISIT,
        S_QUP,
        S_QFIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_kind  kind;
        t_coord x_low;
        t_coord x_high;
        t_coord y_low;
        t_coord y_high;
        t_depth depth;
    } t_item;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_depth wdata;
        t_addr  raddr;
    } t_ram_req;

    typedef struct packed {
        logic clear;
        logic take;
    } t_acc_ctl;

    typedef struct packed {
        logic load;
        logic err;
    } t_res_ctl;

    function automatic logic in_grid(input t_coord c);
        return int'(c) < SIDE;
    endfunction

    function automatic t_addr level_base(input t_lvl lvl);
        t_addr b;
        b = '0;
        for (int i = 0; i < SIDE_LOG2; i++) begin
            if (t_lvl'(i) < lvl) begin
                b = b + t_addr'(1 << (2 * (SIDE_LOG2 - i)));
            end
        end
        return b;
    endfunction

    function automatic t_addr node_addr(input t_lvl lvl, input t_xy nx, input t_xy ny);
        t_lvl sh;
        sh = TOP_LVL - lvl;
        return level_base(lvl) + (t_addr'(ny) << sh) + t_addr'(nx);
    endfunction

endpackage

FILE: hdl/hdmp_if.sv
// ----------------------------------------------------------------------------
// hdmp_in_if / hdmp_out_if: item and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface hdmp_in_if import hdmp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord x_low;
    t_coord x_high;
    t_coord y_low;
    t_coord y_high;
    t_depth depth;
    logic [1:0] kind;

    modport source (output valid, kind, x_low, x_high, y_low, y_high, depth, input ready);
    modport sink   (input valid, kind, x_low, x_high, y_low, y_high, depth, output ready);
endinterface

interface hdmp_out_if import hdmp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_depth max_depth;
    logic   error;

    modport source (output valid, max_depth, error, input ready);
    modport sink   (input valid, max_depth, error, output ready);
endinterface

FILE: hdl/hdmp_ram.sv
// ----------------------------------------------------------------------------
// hdmp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hdmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hdmp_max.sv
// ----------------------------------------------------------------------------
// hdmp_max: shared running-maximum unit
// Folds RAM read data into an accumulator; clear restarts it at zero.
// ----------------------------------------------------------------------------
module hdmp_max import hdmp_pkg::*; (
    input  logic     i_clk,
    input  t_acc_ctl i_ctl,
    input  t_depth   i_data,
    output t_depth   o_acc,
    output t_depth   o_next
);

    t_depth r_acc;
    t_depth n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.take && (i_data > r_acc)) begin
            n_acc = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc  = r_acc;
    assign o_next = n_acc;

endmodule

FILE: hdl/hdmp_seq.sv
// ----------------------------------------------------------------------------
// hdmp_seq: pyramid sequencer
// Steps pixel writes, ancestor rebuilds, quadtree query walks and clears.
// ----------------------------------------------------------------------------
module hdmp_seq import hdmp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_item    i_item,
    input  t_depth   i_bg,
    input  t_depth   i_acc_next,
    input  logic     i_out_free,
    output t_ram_req o_ram,
    output t_acc_ctl o_acc_ctl,
    output t_res_ctl o_res
);

    t_state r_state, n_state;
    t_addr  r_cnt, n_cnt;
    t_lvl   r_lvl, n_lvl;
    logic [1:0] r_k, n_k;
    t_xy    r_nx, n_nx, r_ny, n_ny;
    t_xy    r_xl, n_xl, r_xh, n_xh, r_yl, n_yl, r_yh, n_yh;
    t_depth r_depth, n_depth;
    t_depth r_clr_data, n_clr_data;
    logic   r_err, n_err;
    logic   r_rd_pend;
    logic   rd_issue;

    logic   q_bad, w_ok;
    t_xy    x0, x1, y0, y1, lmask;
    logic   covered, overlap, visit_adv, at_root, last_child;
    t_xy    par_x, par_y, ch_x, ch_y;

    assign q_bad = (i_item.x_low > i_item.x_high) || (i_item.y_low > i_item.y_high)
                || !in_grid(i_item.x_high) || !in_grid(i_item.y_high);
    assign w_ok  = in_grid(i_item.x_low) && in_grid(i_item.y_low);

    assign lmask      = ~(t_xy'('1) << r_lvl);
    assign x0         = r_nx << r_lvl;
    assign x1         = x0 | lmask;
    assign y0         = r_ny << r_lvl;
    assign y1         = y0 | lmask;
    assign covered    = (r_xl <= x0) && (x1 <= r_xh) && (r_yl <= y0) && (y1 <= r_yh);
    assign overlap    = (x0 <= r_xh) && (r_xl <= x1) && (y0 <= r_yh) && (r_yl <= y1);
    assign visit_adv  = covered || !overlap || (r_lvl == '0);
    assign at_root    = (r_lvl == TOP_LVL);
    assign last_child = r_nx[0] & r_ny[0];

    assign par_x = r_xl >> r_lvl;
    assign par_y = r_yl >> r_lvl;
    assign ch_x  = (par_x << 1) | t_xy'(r_k[0]);
    assign ch_y  = (par_y << 1) | t_xy'(r_k[1]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_cnt == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_item.kind)
                        KIND_WRITE: begin
                            if (w_ok) begin
                                n_state = S_WPIX;
                            end
                        end
                        KIND_QUERY: begin
                            n_state = q_bad ? S_EMIT : S_QVISIT;
                        end
                        KIND_CLEAR: begin
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WPIX: begin
                n_state = S_WRD;
            end
            S_WRD: begin
                if (r_k == 2'd3) begin
                    n_state = S_WWB;
                end
            end
            S_WWB: begin
                n_state = at_root ? S_IDLE : S_WRD;
            end
            S_QVISIT, S_QUP: begin
                if ((r_state == S_QUP) || visit_adv) begin
                    if (at_root) begin
                        n_state = S_QFIN;
                    end else if (last_child) begin
                        n_state = S_QUP;
                    end else begin
                        n_state = S_QVISIT;
                    end
                end
            end
            S_QFIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = 1'b0;
        rd_issue    = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_cnt;
        o_ram.wdata = r_clr_data;
        o_ram.raddr = node_addr(r_lvl, r_nx, r_ny);
        o_res.load  = 1'b0;
        o_res.err   = r_err;
        case (r_state)
            S_CLR: begin
                o_ram.we = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_WPIX: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = node_addr('0, r_xl, r_yl);
                o_ram.wdata = r_depth;
            end
            S_WRD: begin
                o_ram.raddr = node_addr(r_lvl - t_lvl'(1), ch_x, ch_y);
                rd_issue    = 1'b1;
            end
            S_WWB: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = node_addr(r_lvl, par_x, par_y);
                o_ram.wdata = i_acc_next;
            end
            S_QVISIT: begin
                rd_issue = covered;
            end
            S_EMIT: begin
                o_res.load = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        o_acc_ctl.take  = r_rd_pend;
        o_acc_ctl.clear = (r_state == S_IDLE) || (r_state == S_WWB);
    end

    // datapath
    always_comb begin
        n_cnt      = r_cnt;
        n_lvl      = r_lvl;
        n_k        = r_k;
        n_nx       = r_nx;
        n_ny       = r_ny;
        n_xl       = r_xl;
        n_xh       = r_xh;
        n_yl       = r_yl;
        n_yh       = r_yh;
        n_depth    = r_depth;
        n_clr_data = r_clr_data;
        n_err      = r_err;
        case (r_state)
            S_CLR: begin
                n_cnt = r_cnt + t_addr'(1);
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_xl       = t_xy'(i_item.x_low);
                    n_xh       = t_xy'(i_item.x_high);
                    n_yl       = t_xy'(i_item.y_low);
                    n_yh       = t_xy'(i_item.y_high);
                    n_depth    = i_item.depth;
                    n_err      = q_bad;
                    n_lvl      = TOP_LVL;
                    n_nx       = '0;
                    n_ny       = '0;
                    n_cnt      = '0;
                    n_clr_data = i_bg;
                end
            end
            S_WPIX: begin
                n_lvl = t_lvl'(1);
                n_k   = '0;
            end
            S_WRD: begin
                n_k = r_k + 2'd1;
            end
            S_WWB: begin
                n_k = '0;
                if (!at_root) begin
                    n_lvl = r_lvl + t_lvl'(1);
                end
            end
            S_QVISIT, S_QUP: begin
                if ((r_state == S_QVISIT) && !visit_adv) begin
                    n_lvl = r_lvl - t_lvl'(1);
                    n_nx  = r_nx << 1;
                    n_ny  = r_ny << 1;
                end else if (!at_root) begin
                    if (last_child) begin
                        n_lvl = r_lvl + t_lvl'(1);
                        n_nx  = r_nx >> 1;
                        n_ny  = r_ny >> 1;
                    end else if (!r_nx[0]) begin
                        n_nx[0] = 1'b1;
                    end else begin
                        n_nx[0] = 1'b0;
                        n_ny[0] = 1'b1;
                    end
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_clr_data <= '1;
            r_rd_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_clr_data <= n_clr_data;
            r_rd_pend  <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl   <= n_lvl;
        r_k     <= n_k;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_xl    <= n_xl;
        r_xh    <= n_xh;
        r_yl    <= n_yl;
        r_yh    <= n_yh;
        r_depth <= n_depth;
        r_err   <= n_err;
    end

`ifndef SYNTH
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ($past(r_state) == S_WRD || $past(r_state) == S_QVISIT))
        else $error("read data arrived without a read issued");
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_rd_pend)
        else $error("result emitted with a read still in flight");
    a_wb_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WWB) |-> (r_rd_pend && $past(r_k) == 2'd3))
        else $error("parent written before fourth child read");
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QVISIT || r_state == S_QUP || r_state == S_WRD) |-> (r_lvl <= TOP_LVL))
        else $error("level out of range");
`endif

endmodule

FILE: hdl/hierarchical_depth_max_pyramid.sv
// ----------------------------------------------------------------------------
// hierarchical_depth_max_pyramid: max-depth quadtree over a square grid
// Holds a pyramid of maximum depths in one RAM and answers rectangle queries.
// ----------------------------------------------------------------------------
// After reset and after every clear item, a clearing pass writes the
// background depth into all 5461 pyramid entries, one entry a cycle, and no
// item is taken meanwhile. A pixel write stores the pixel, then rebuilds
// each of the six levels above it with four child reads through the single
// read port of the pyramid RAM and one parent write. A query walks the
// quadtree one node a cycle, counting the climbs back up, and finishes
// through the states S_QFIN and S_EMIT; its length follows the number of
// boundary nodes of the rectangle. A bad rectangle goes straight to S_EMIT
// for its error result. The result sits in an output register until its
// transfer, and one item is in work at a time.
module hierarchical_depth_max_pyramid import hdmp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_depth        i_cfg_wdata,
    hdmp_in_if.sink       i_in,
    hdmp_out_if.source    o_out
);

    t_depth   r_bg;
    logic     r_out_valid;
    t_depth   r_out_max;
    logic     r_out_err;
    t_item    item;
    t_ram_req ram_req;
    t_acc_ctl acc_ctl;
    t_res_ctl res_ctl;
    t_depth   rd_data, acc, acc_next;
    logic     out_free;

    assign item.kind   = t_kind'(i_in.kind);
    assign item.x_low  = i_in.x_low;
    assign item.x_high = i_in.x_high;
    assign item.y_low  = i_in.y_low;
    assign item.y_high = i_in.y_high;
    assign item.depth  = i_in.depth;

    assign out_free = !r_out_valid || o_out.ready;

    hdmp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_item     (item),
        .i_bg       (r_bg),
        .i_acc_next (acc_next),
        .i_out_free (out_free),
        .o_ram      (ram_req),
        .o_acc_ctl  (acc_ctl),
        .o_res      (res_ctl)
    );

    hdmp_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (PYR_TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    hdmp_max u_max (
        .i_clk  (i_clk),
        .i_ctl  (acc_ctl),
        .i_data (rd_data),
        .o_acc  (acc),
        .o_next (acc_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= '1;
        end else if (i_cfg_we) begin
            r_bg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ctl.load) begin
            r_out_max <= res_ctl.err ? '0 : acc;
            r_out_err <= res_ctl.err;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.max_depth = r_out_max;
    assign o_out.error     = r_out_err;

endmodule
